/* design/ght_pkg.sv */
// shared types and codes for the generational handle table
`default_nettype none

package ght_pkg;

    localparam int REF_W  = 32;
    localparam int SLOT_W = 10;
    localparam int GENF_W = 16;
    localparam int USE_W  = 11;
    localparam int STAT_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_STALE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ZREF  = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [REF_W-1:0]  object_ref;
        logic [SLOT_W-1:0] slot_index;
        logic [GENF_W-1:0] generation;
    } ght_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] handle_slot;
        logic [GENF_W-1:0] handle_generation;
        logic [USE_W-1:0]  slots_in_use;
    } ght_result_t;

endpackage

`default_nettype wire

/* design/generational_handle_table.sv */
// generational handle table: top level with stream ports and output register
// input to result handshake: an allocate reads slots from the cursor, one per cycle, until one
//   is free or all were read; a free reads its slot; a rejected allocate or out-of-range free
//   skips the memory read
// throughput: one word at a time, next word taken once the result is in the output register
// reset: aresetn low clears count and cursor, then a clearing pass zeroes the slot memory with s_tready low
`default_nettype none

module generational_handle_table #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] object_ref, [41:32] slot_index, [57:42] generation, [63:58] zero
    input  wire logic [63:0] s_tdata,
    // [0] operation
    input  wire logic [0:0]  s_tuser,
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [11:2] handle_slot, [27:12] handle_generation,
    // [38:28] slots_in_use, [39] zero
    output logic [39:0]      m_tdata
);

    import ght_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int ENT_W = REF_W + GEN_BITS;

    ght_req_t    req;
    ght_result_t res;
    logic        res_valid;
    logic        res_ready;

    // memory port between sequencer and slot store
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    // output register
    logic        m_valid_reg, m_valid_next;
    ght_result_t m_res_reg, m_res_next;

    // unpack the input word
    assign req.operation  = s_tuser[0];
    assign req.object_ref = s_tdata[31:0];
    assign req.slot_index = s_tdata[41:32];
    assign req.generation = s_tdata[57:42];

    ght_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W),
        .DW    (ENT_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ght_engine #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // result register frees the sequencer while the word waits downstream
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.slots_in_use, m_res_reg.handle_generation,
                       m_res_reg.handle_slot, m_res_reg.status};

endmodule

`default_nettype wire

/* design/ght_slot_ram.sv */
// slot table memory: one write port, one registered read port
`default_nettype none

module ght_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/ght_engine.sv */
// sequencer: clearing pass, allocate scan and free check over the slot memory
`default_nettype none

module ght_engine #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_BITS   = 16,
    parameter int IDX_W      = 10,
    parameter int CNT_W      = 11
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ght_pkg::ght_req_t                   req,
    input  wire logic                                req_valid,
    output logic                                     req_ready,
    output logic                                     rd_en,
    output logic [IDX_W-1:0]                         rd_addr,
    input  wire logic [ght_pkg::REF_W+GEN_BITS-1:0]  rd_data,
    output logic                                     wr_en,
    output logic [IDX_W-1:0]                         wr_addr,
    output logic [ght_pkg::REF_W+GEN_BITS-1:0]       wr_data,
    output ght_pkg::ght_result_t                     res,
    output logic                                     res_valid,
    input  wire logic                                res_ready
);

    import ght_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] LAST_TRY = CNT_W'(SLOT_COUNT - 1);

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    chk_reg, chk_next;
    logic [CNT_W-1:0]    tries_reg, tries_next;
    logic [REF_W-1:0]    ref_reg, ref_next;
    logic [GENF_W-1:0]   gen_in_reg, gen_in_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [GENF_W-1:0]   gen_out_reg, gen_out_next;

    logic [REF_W-1:0]    ent_ref;
    logic [GEN_BITS-1:0] ent_gen;
    logic [GEN_BITS-1:0] gen_inc;
    logic [31:0]         ent_gen32, inc_gen32, in_gen32, chk32, cnt32, idx32;
    logic [IDX_W-1:0]    chk_adv;
    logic                idx_out_of_range;
    logic                table_full;

    assign ent_ref   = rd_data[REF_W-1:0];
    assign ent_gen   = rd_data[REF_W +: GEN_BITS];
    assign gen_inc   = ent_gen + GEN_BITS'(1);
    assign ent_gen32 = 32'(ent_gen);
    assign inc_gen32 = 32'(gen_inc);
    assign in_gen32  = 32'(gen_in_reg);
    assign chk32     = 32'(chk_reg);
    assign cnt32     = 32'(count_reg);
    assign idx32     = 32'(req.slot_index);
    assign chk_adv   = (chk_reg == LAST_IDX) ? '0 : chk_reg + IDX_W'(1);

    assign idx_out_of_range = idx32 >= 32'(SLOT_COUNT);
    assign table_full       = cnt32 >= 32'(SLOT_COUNT);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    assign res.status            = stat_reg;
    assign res.handle_slot       = slot_reg;
    assign res.handle_generation = gen_out_reg;
    assign res.slots_in_use      = cnt32[USE_W-1:0];

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cursor_next  = cursor_reg;
        count_next   = count_reg;
        chk_next     = chk_reg;
        tries_next   = tries_reg;
        ref_next     = ref_reg;
        gen_in_next  = gen_in_reg;
        idx_next     = idx_reg;
        stat_next    = stat_reg;
        slot_next    = slot_reg;
        gen_out_next = gen_out_reg;
        rd_en        = 1'b0;
        rd_addr      = chk_reg;
        wr_en        = 1'b0;
        wr_addr      = chk_reg;
        wr_data      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // zero one entry per cycle after reset
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_valid) begin
                    ref_next    = req.object_ref;
                    gen_in_next = req.generation;
                    idx_next    = idx32[IDX_W-1:0];
                    if (req.operation == OP_ALLOC) begin
                        if (table_full) begin
                            stat_next    = STAT_FULL;
                            slot_next    = '0;
                            gen_out_next = '0;
                            state_next   = S_RESP;
                        end else if (req.object_ref == '0) begin
                            stat_next    = STAT_ZREF;
                            slot_next    = '0;
                            gen_out_next = '0;
                            state_next   = S_RESP;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = cursor_reg;
                            chk_next   = cursor_reg;
                            tries_next = '0;
                            state_next = S_SCAN;
                        end
                    end else begin
                        if (idx_out_of_range) begin
                            stat_next    = STAT_STALE;
                            slot_next    = req.slot_index;
                            gen_out_next = '0;
                            state_next   = S_RESP;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = idx32[IDX_W-1:0];
                            state_next = S_FREE;
                        end
                    end
                end
            end
            S_SCAN: begin
                // rd_data holds the entry at chk_reg; if that slot is taken, the next slot is read meanwhile
                if (ent_ref == '0) begin
                    wr_en        = 1'b1;
                    wr_addr      = chk_reg;
                    wr_data      = {gen_inc, ref_reg};
                    cursor_next  = chk_reg;
                    count_next   = count_reg + CNT_W'(1);
                    stat_next    = STAT_OK;
                    slot_next    = chk32[SLOT_W-1:0];
                    gen_out_next = inc_gen32[GENF_W-1:0];
                    state_next   = S_RESP;
                end else if (tries_reg == LAST_TRY) begin
                    stat_next    = STAT_FULL;
                    slot_next    = '0;
                    gen_out_next = '0;
                    state_next   = S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = chk_adv;
                    chk_next   = chk_adv;
                    tries_next = tries_reg + CNT_W'(1);
                end
            end
            S_FREE: begin
                slot_next = 32'(idx_reg) >= 32'(1 << SLOT_W) ? '0 : SLOT_W'(idx_reg);
                if (ent_ref == '0 || ent_gen32 != in_gen32) begin
                    stat_next    = STAT_STALE;
                    gen_out_next = ent_gen32[GENF_W-1:0];
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg;
                    wr_data      = {gen_inc, {REF_W{1'b0}}};
                    stat_next    = STAT_OK;
                    gen_out_next = inc_gen32[GENF_W-1:0];
                    if (count_reg != '0) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            cursor_reg <= '0;
            count_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_reg     <= chk_next;
        tries_reg   <= tries_next;
        ref_reg     <= ref_next;
        gen_in_reg  <= gen_in_next;
        idx_reg     <= idx_next;
        stat_reg    <= stat_next;
        slot_reg    <= slot_next;
        gen_out_reg <= gen_out_next;
    end

endmodule

`default_nettype wire

/* tb/sv/ght_table_checker.sv */
// checker for the generational handle table: predicts each result word and compares it
`timescale 1ns / 100ps

module ght_table_checker #(
    parameter int SLOT_COUNT = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    output int               failures,
    output int               outstanding
);

    import ght_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the table
    logic [REF_W-1:0]  slot_owner [SLOT_COUNT];
    logic [GENF_W-1:0] slot_tag   [SLOT_COUNT];
    logic [USE_W-1:0]  occupied;
    logic [SLOT_W-1:0] cursor;

    ght_result_t expected_results [$];
    ght_req_t    req_word;
    ght_result_t got_word;
    ght_result_t want_word;
    int          fail_total = 0;

    // applies one request to the shadow table and returns the result word it should give
    function automatic ght_result_t apply_table_op(input ght_req_t req);
        ght_result_t       res;
        logic [SLOT_W-1:0] probe;
        logic              found;
        res = '0;
        if (req.operation == OP_ALLOC) begin
            if (occupied >= SLOT_COUNT) begin
                res.status = STAT_FULL;
            end else if (req.object_ref == '0) begin
                res.status = STAT_ZREF;
            end else begin
                // round-robin scan, starting on the slot allocated last
                probe = cursor;
                found = 1'b0;
                for (int n = 0; n < SLOT_COUNT; n++) begin
                    if (!found) begin
                        if (slot_owner[probe] == '0) begin
                            found = 1'b1;
                        end else begin
                            probe = (probe == SLOT_COUNT - 1) ? '0 : probe + 1'b1;
                        end
                    end
                end
                if (!found) begin
                    res.status = STAT_FULL;
                end else begin
                    cursor            = probe;
                    slot_owner[probe] = req.object_ref;
                    slot_tag[probe]   = slot_tag[probe] + 1'b1;
                    occupied          = occupied + 1'b1;
                    res.status            = STAT_OK;
                    res.handle_slot       = probe;
                    res.handle_generation = slot_tag[probe];
                end
            end
        end else begin
            res.handle_slot       = req.slot_index;
            res.handle_generation = slot_tag[req.slot_index];
            if (slot_owner[req.slot_index] == '0 ||
                slot_tag[req.slot_index] != req.generation) begin
                res.status = STAT_STALE;
            end else begin
                slot_owner[req.slot_index] = '0;
                slot_tag[req.slot_index]   = slot_tag[req.slot_index] + 1'b1;
                if (occupied != '0) begin
                    occupied = occupied - 1'b1;
                end
                res.status            = STAT_OK;
                res.handle_generation = slot_tag[req.slot_index];
            end
        end
        res.slots_in_use = occupied;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_owner[i] = '0;
                slot_tag[i]   = '0;
            end
            occupied = '0;
            cursor   = '0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                req_word.operation  = s_tuser[0];
                req_word.object_ref = s_tdata[31:0];
                req_word.slot_index = s_tdata[41:32];
                req_word.generation = s_tdata[57:42];
                expected_results.push_back(apply_table_op(req_word));
            end
            if (m_tvalid && m_tready) begin
                got_word.status            = m_tdata[1:0];
                got_word.handle_slot       = m_tdata[11:2];
                got_word.handle_generation = m_tdata[27:12];
                got_word.slots_in_use      = m_tdata[38:28];
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result word %h", $realtime, m_tdata);
                    end
                end else begin
                    want_word = expected_results.pop_front();
                    if (got_word.status !== want_word.status ||
                        got_word.handle_slot !== want_word.handle_slot ||
                        got_word.handle_generation !== want_word.handle_generation ||
                        got_word.slots_in_use !== want_word.slots_in_use) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("%0t: expected status %0d slot %0d gen %0d used %0d",
                                     $realtime, want_word.status, want_word.handle_slot,
                                     want_word.handle_generation, want_word.slots_in_use);
                            $display("%0t: got      status %0d slot %0d gen %0d used %0d",
                                     $realtime, got_word.status, got_word.handle_slot,
                                     got_word.handle_generation, got_word.slots_in_use);
                        end
                    end
                end
            end
        end
        failures    <= fail_total;
        outstanding <= expected_results.size();
    end

endmodule

/* tb/sv/generational_handle_table_test.sv */
// testbench top for the generational handle table: stimulus, idling and verdict
`timescale 1ns / 100ps

module generational_handle_table_test;

    import ght_pkg::*;

    localparam int SLOT_COUNT = 1024;
    // longest stretch with no word moving: clearing pass or a full-table scan plus stalls
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [GENF_W-1:0] gen;
    } handle_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] object_ref, [41:32] slot_index, [57:42] generation
    logic [0:0]  s_tuser  = '0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [1:0] status, [11:2] slot, [27:12] generation, [38:28] in use

    int failures;
    int outstanding;

    // idle rates in percent of cycles
    int send_idle_pct = 15;
    int recv_idle_pct = 70;

    // handles known to be live, handles already given back, ops waiting on their result
    handle_t live_handles [$];
    handle_t retired_handles [$];
    logic    ops_in_flight [$];
    int      full_seen = 0;
    int      quiet_cycles = 0;
    logic    done_op;

    generational_handle_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GENF_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ght_table_checker #(
        .SLOT_COUNT (SLOT_COUNT)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver side: random back-pressure at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // learn handles from the result words so that frees can use real handles
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && ops_in_flight.size() > 0) begin
            done_op = ops_in_flight.pop_front();
            if (m_tdata[1:0] == STAT_FULL) begin
                full_seen++;
            end
            if (m_tdata[1:0] == STAT_OK) begin
                if (done_op == OP_ALLOC) begin
                    live_handles.push_back({m_tdata[11:2], m_tdata[27:12]});
                end else begin
                    // slot went free, possibly through a handle guessed by noise
                    for (int i = live_handles.size() - 1; i >= 0; i--) begin
                        if (live_handles[i].slot == m_tdata[11:2]) begin
                            live_handles.delete(i);
                        end
                    end
                end
            end
        end
    end

    // watchdog: ends the run when no word moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // offers one word and returns at the edge where it is taken
    task automatic send_word(input logic op, input logic [REF_W-1:0] oref,
                             input logic [SLOT_W-1:0] idx, input logic [GENF_W-1:0] gen);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, gen, idx, oref};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        ops_in_flight.push_back(op);
    endtask

    // one random word: allocate, free a live handle, or noise
    task automatic send_random_word(input int alloc_pct, input int free_pct);
        int                pick;
        int                k;
        handle_t           h;
        logic [GENF_W-1:0] flip;
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
            send_word(OP_ALLOC, $urandom(), SLOT_W'($urandom()), GENF_W'($urandom()));
        end else if (pick < alloc_pct + free_pct && live_handles.size() > 0) begin
            k = $urandom_range(live_handles.size() - 1);
            h = live_handles[k];
            live_handles.delete(k);
            retired_handles.push_back(h);
            if (retired_handles.size() > 64) begin
                void'(retired_handles.pop_front());
            end
            send_word(OP_FREE, $urandom(), h.slot, h.gen);
        end else begin
            case ($urandom_range(3))
                0: begin
                    // zero reference on allocate
                    send_word(OP_ALLOC, '0, SLOT_W'($urandom()), GENF_W'($urandom()));
                end
                1: begin
                    // random handle, nearly always stale
                    send_word(OP_FREE, $urandom(), SLOT_W'($urandom()), GENF_W'($urandom()));
                end
                2: begin
                    // double free of a handle given back earlier
                    if (retired_handles.size() > 0) begin
                        h = retired_handles[$urandom_range(retired_handles.size() - 1)];
                    end else begin
                        h.slot = SLOT_W'($urandom());
                        h.gen  = GENF_W'($urandom());
                    end
                    send_word(OP_FREE, $urandom(), h.slot, h.gen);
                end
                default: begin
                    // live slot, wrong generation: handle stays live
                    if (live_handles.size() > 0) begin
                        h = live_handles[$urandom_range(live_handles.size() - 1)];
                    end else begin
                        h.slot = SLOT_W'($urandom());
                        h.gen  = GENF_W'($urandom());
                    end
                    flip = GENF_W'($urandom_range(65535, 1));
                    send_word(OP_FREE, $urandom(), h.slot, h.gen ^ flip);
                end
            endcase
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words: empty and mismatched frees, zero reference, extreme values
        send_word(OP_FREE,  32'h0000_0000, 10'd0,    16'h0000);  // free of an empty slot
        send_word(OP_ALLOC, 32'h0000_0000, 10'd0,    16'h0000);  // zero reference
        send_word(OP_ALLOC, 32'hFFFF_FFFF, 10'h3FF,  16'hFFFF);  // slot 0, gen 1
        send_word(OP_ALLOC, 32'h0000_0001, 10'd0,    16'h0000);  // scan skips slot 0
        send_word(OP_FREE,  32'hFFFF_FFFF, 10'd0,    16'h0000);  // generation mismatch
        send_word(OP_FREE,  32'h0000_0000, 10'd0,    16'hFFFF);  // generation mismatch
        send_word(OP_FREE,  32'h0000_0000, 10'h3FF,  16'hFFFF);  // last slot, empty
        send_word(OP_FREE,  32'h0000_0000, 10'd0,    16'h0001);  // good free of slot 0
        send_word(OP_FREE,  32'h0000_0000, 10'd0,    16'h0001);  // same handle again
        send_word(OP_FREE,  32'h0000_0000, 10'd0,    16'h0002);  // empty slot, current gen
        send_word(OP_ALLOC, 32'hA5A5_5A5A, 10'h155,  16'hAAAA);  // scan goes on from slot 1
        send_word(OP_FREE,  32'h5A5A_A5A5, 10'd1,    16'h0001);  // good free of slot 1
        send_word(OP_ALLOC, 32'h8000_0000, 10'h2AA,  16'h5555);
        send_word(OP_ALLOC, 32'h0000_0000, 10'h3FF,  16'hFFFF);  // zero reference again

        // mixed traffic, slow receiver
        repeat (80) send_random_word(55, 35);

        // fill the table up to full and keep hitting it, slow sender
        send_idle_pct = 70;
        recv_idle_pct = 15;
        for (int n = 0; n < 1400 && full_seen < 30; n++) begin
            send_random_word(92, 4);
        end

        // drain at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (80) send_random_word(20, 70);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        // room for a stray extra result word
        repeat (16) @(posedge aclk);

        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
